### sv/ess_pkg.sv
// Shared types and constants of the engagement state and set-speed block.
package ess_pkg;

  // Speed limits in kph.
  localparam logic [7:0] SPEED_MAX        = 8'd144;
  localparam logic [7:0] SPEED_MIN        = 8'd8;
  localparam logic [7:0] SPEED_STEP       = 8'd8;
  localparam logic [7:0] ENGAGE_SPEED_MIN = 8'd40;
  localparam logic [7:0] NEVER_SET_LIMIT  = 8'd250;
  localparam logic [7:0] SPEED_NEVER_SET  = 8'd255;

  // Ego speed bounds and rounding, 4 fraction bits.
  localparam logic [11:0] ENGAGE_Q4_MIN = 12'(ENGAGE_SPEED_MIN) << 4;
  localparam logic [11:0] ENGAGE_Q4_MAX = 12'(SPEED_MAX) << 4;
  localparam logic [11:0] Q4_HALF       = 12'd8;

  // Register reset values.
  localparam logic       CRUISE_LOGIC_RESET = 1'b1;
  localparam logic [9:0] SOFT_FRAMES_RESET  = 10'd300;

  // Operation codes.
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_FRAME  = 1'b1;

  // Button kinds; the unused code acts as other.
  localparam logic [1:0] BTN_OTHER = 2'd0;
  localparam logic [1:0] BTN_ACCEL = 2'd1;
  localparam logic [1:0] BTN_DECEL = 2'd2;

  // Configuration register indexes.
  typedef enum logic {
    CFG_CRUISE_LOGIC_ENABLE = 1'b0,
    CFG_SOFT_DISABLE_FRAMES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        operation;
    logic [1:0]  button_kind;
    logic        button_pressed;
    logic        ev_enable;
    logic        ev_no_entry;
    logic        ev_pre_enable;
    logic        ev_user_disable;
    logic        ev_soft_disable;
    logic        ev_immediate_disable;
    logic [11:0] ego_speed_kph_q4;
  } ess_in_t;

  typedef struct packed {
    logic [1:0] engage_state;
    logic       is_enabled;
    logic       is_active;
    logic [7:0] set_speed_kph;
    logic [9:0] soft_timer_left;
  } ess_out_t;

endpackage

### sv/engagement_state_with_set_speed.sv
// Engagement state machine with cruise set-speed logic, top level.
//
// The block takes one input word per cycle while not stalled and returns
// exactly one result word for each, showing the engagement state, set speed
// and soft-disable timer after that word. A button word (operation 0) carries
// one cruise button event: while engaged and cruise logic is on, a released
// accel moves the set speed up to the next multiple of 8 kph and a released
// decel down to the previous one, clipped to 8..144 kph; any released button
// clips. A frame word (operation 1) counts the soft-disable timer down,
// applies the state transitions and initializes the set speed on engagement,
// either from the previous frame's set speed (when an accel arrived this
// frame and that speed is under 250 kph) or from the ego speed clipped to
// 40..144 kph and rounded. Each accepted word sits in the input register, and
// one pass of the state logic then loads the result register, where the
// result waits until it is taken. The output register lets one new word enter
// while a result waits. Configuration writes are always ready and must only
// be issued while no word is in flight.
module engagement_state_with_set_speed (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ess_pkg::ess_in_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ess_pkg::ess_out_t out_word_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  ess_pkg::cfg_reg_e cfg_index_i,
  input  logic [9:0]      cfg_data_i
);

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_PRE      = 2'd1,
    MODE_ENABLED  = 2'd2,
    MODE_SOFT     = 2'd3
  } mode_e;

  // Configuration registers.
  logic       cruise_logic_enable_q;
  logic [9:0] soft_disable_frames_q;

  // Pipeline registers.
  logic              in_valid_q;
  ess_pkg::ess_in_t  in_word_q;
  logic              out_valid_q;
  ess_pkg::ess_out_t out_word_q;

  // Block state.
  mode_e      mode_q, mode_d;
  logic [7:0] set_speed_q, set_speed_d;
  logic [7:0] frame_start_q, frame_start_d;
  logic       accel_seen_q, accel_seen_d;
  logic [9:0] soft_timer_q, soft_timer_d;

  logic              advance;
  logic              in_accept;
  ess_pkg::ess_out_t result;

  // Button arithmetic.
  logic [8:0] speed_up;
  logic [8:0] speed_down;
  logic [8:0] speed_step;
  logic [7:0] speed_clipped;

  // Frame arithmetic.
  logic [9:0]  timer_dec;
  logic [11:0] ego_clipped;
  logic [11:0] ego_rounded;
  logic [7:0]  engage_speed;

  // Hand the word to the result register whenever that register is free or
  // being emptied this cycle.
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Accel: next higher multiple of 8. Decel: next lower multiple of 8, which
  // goes below the minimum (and clips there) for any speed of 8 or less.
  assign speed_up = {1'b0, set_speed_q[7:3], 3'b000} + 9'(ess_pkg::SPEED_STEP);

  always_comb begin
    if (set_speed_q[7:3] == 5'd0) begin
      speed_down = 9'd0;
    end else if (set_speed_q[2:0] == 3'd0) begin
      speed_down = {1'b0, set_speed_q} - 9'(ess_pkg::SPEED_STEP);
    end else begin
      speed_down = {1'b0, set_speed_q[7:3], 3'b000};
    end
  end

  always_comb begin
    unique case (in_word_q.button_kind)
      ess_pkg::BTN_ACCEL: speed_step = speed_up;
      ess_pkg::BTN_DECEL: speed_step = speed_down;
      default:            speed_step = {1'b0, set_speed_q};
    endcase
  end

  always_comb begin
    if (speed_step < 9'(ess_pkg::SPEED_MIN)) begin
      speed_clipped = ess_pkg::SPEED_MIN;
    end else if (speed_step > 9'(ess_pkg::SPEED_MAX)) begin
      speed_clipped = ess_pkg::SPEED_MAX;
    end else begin
      speed_clipped = speed_step[7:0];
    end
  end

  // Saturating countdown, then the ego speed clipped and rounded half up.
  assign timer_dec = (soft_timer_q != 10'd0) ? soft_timer_q - 10'd1 : 10'd0;

  always_comb begin
    if (in_word_q.ego_speed_kph_q4 < ess_pkg::ENGAGE_Q4_MIN) begin
      ego_clipped = ess_pkg::ENGAGE_Q4_MIN;
    end else if (in_word_q.ego_speed_kph_q4 > ess_pkg::ENGAGE_Q4_MAX) begin
      ego_clipped = ess_pkg::ENGAGE_Q4_MAX;
    end else begin
      ego_clipped = in_word_q.ego_speed_kph_q4;
    end
  end

  assign ego_rounded  = ego_clipped + ess_pkg::Q4_HALF;
  assign engage_speed = ego_rounded[11:4];

  // Next state for the word in the input register.
  always_comb begin
    mode_d        = mode_q;
    set_speed_d   = set_speed_q;
    frame_start_d = frame_start_q;
    accel_seen_d  = accel_seen_q;
    soft_timer_d  = soft_timer_q;

    if (in_word_q.operation == ess_pkg::OP_BUTTON) begin
      // Note any accel, pressed or released, for engagement in this frame.
      if (in_word_q.button_kind == ess_pkg::BTN_ACCEL) begin
        accel_seen_d = 1'b1;
      end
      if (cruise_logic_enable_q && (mode_q != MODE_DISABLED) &&
          !in_word_q.button_pressed) begin
        set_speed_d = speed_clipped;
      end
    end else begin
      soft_timer_d = timer_dec;
      unique case (mode_q)
        MODE_DISABLED: begin
          if (in_word_q.ev_enable && !in_word_q.ev_no_entry) begin
            mode_d = in_word_q.ev_pre_enable ? MODE_PRE : MODE_ENABLED;
            if (accel_seen_q && (frame_start_q < ess_pkg::NEVER_SET_LIMIT)) begin
              set_speed_d = frame_start_q;
            end else begin
              set_speed_d = engage_speed;
            end
          end
        end
        MODE_ENABLED: begin
          priority if (in_word_q.ev_user_disable || in_word_q.ev_immediate_disable) begin
            mode_d = MODE_DISABLED;
          end else if (in_word_q.ev_soft_disable) begin
            mode_d       = MODE_SOFT;
            soft_timer_d = soft_disable_frames_q;
          end else begin
            mode_d = mode_q;
          end
        end
        MODE_SOFT: begin
          priority if (in_word_q.ev_user_disable || in_word_q.ev_immediate_disable) begin
            mode_d = MODE_DISABLED;
          end else if (!in_word_q.ev_soft_disable) begin
            mode_d = MODE_ENABLED;
          end else if (timer_dec == 10'd0) begin
            mode_d = MODE_DISABLED;
          end else begin
            mode_d = mode_q;
          end
        end
        MODE_PRE: begin
          priority if (in_word_q.ev_user_disable || in_word_q.ev_immediate_disable ||
                       in_word_q.ev_soft_disable) begin
            mode_d = MODE_DISABLED;
          end else if (!in_word_q.ev_pre_enable) begin
            mode_d = MODE_ENABLED;
          end else begin
            mode_d = mode_q;
          end
        end
        default: mode_d = MODE_DISABLED;
      endcase
      // Close the frame.
      frame_start_d = set_speed_d;
      accel_seen_d  = 1'b0;
    end
  end

  // Result shows the state after the word.
  always_comb begin
    result.engage_state    = mode_d;
    result.is_enabled      = (mode_d != MODE_DISABLED);
    result.is_active       = (mode_d == MODE_ENABLED) || (mode_d == MODE_SOFT);
    result.set_speed_kph   = set_speed_d;
    result.soft_timer_left = soft_timer_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_logic_enable_q <= ess_pkg::CRUISE_LOGIC_RESET;
      soft_disable_frames_q <= ess_pkg::SOFT_FRAMES_RESET;
      in_valid_q            <= 1'b0;
      in_word_q             <= '0;
      out_valid_q           <= 1'b0;
      out_word_q            <= '0;
      mode_q                <= MODE_DISABLED;
      set_speed_q           <= ess_pkg::SPEED_NEVER_SET;
      frame_start_q         <= ess_pkg::SPEED_NEVER_SET;
      accel_seen_q          <= 1'b0;
      soft_timer_q          <= 10'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ess_pkg::CFG_CRUISE_LOGIC_ENABLE: cruise_logic_enable_q <= cfg_data_i[0];
          ess_pkg::CFG_SOFT_DISABLE_FRAMES: soft_disable_frames_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Input register: load on accept, drop once handed on.
      if (in_accept) begin
        in_valid_q <= 1'b1;
        in_word_q  <= in_word_i;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      // Advance state and result together.
      if (advance) begin
        mode_q        <= mode_d;
        set_speed_q   <= set_speed_d;
        frame_start_q <= frame_start_d;
        accel_seen_q  <= accel_seen_d;
        soft_timer_q  <= soft_timer_d;
        out_valid_q   <= 1'b1;
        out_word_q    <= result;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Set speed is either never set or inside the cruise range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (set_speed_q == ess_pkg::SPEED_NEVER_SET) ||
    ((set_speed_q >= ess_pkg::SPEED_MIN) && (set_speed_q <= ess_pkg::SPEED_MAX)))
    else $error("set speed outside its range");

  // Entering soft-disabling loads the timer from the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SOFT) && ($past(mode_q) == MODE_ENABLED) |->
      (soft_timer_q == $past(soft_disable_frames_q)))
    else $error("soft timer not loaded on entry");

  // State only changes when a word passes to the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(mode_q) && $stable(set_speed_q) && $stable(soft_timer_q))
    else $error("state changed without a word");

endmodule
